@@ sv/igmp_pkg.sv @@
// Shared types, sizes and codes for the group membership table.
// No dependencies; used by every module of the block.
package igmp_pkg;

  localparam int PORT_COUNT      = 3;
  localparam int GROUPS_PER_PORT = 16;
  localparam int TIMER_BITS      = 20;

  localparam int ENTRY_COUNT = PORT_COUNT * GROUPS_PER_PORT;
  localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int PORT_W      = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int K_W         = (GROUPS_PER_PORT > 1) ? $clog2(GROUPS_PER_PORT) : 1;

  // field widths of the request and result
  localparam int REQ_W   = 2;
  localparam int PORTF_W = 2;
  localparam int REC_W   = 8;
  localparam int GRP_W   = 32;
  localparam int FWD_W   = 3;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBUSTNESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_INTV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_INTV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LM_INTV     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LM_COUNT    = 3'd4;

  // timer arithmetic, wide enough for TIMER_BITS up to 32
  localparam int CALC_W = 33;
  localparam logic [CALC_W-1:0] TIMER_SAT = (CALC_W'(1) << TIMER_BITS) - CALC_W'(1);

  // request and record codes
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DATA   = 2'd2;

  localparam logic [REC_W-1:0] REC_IS_EXCLUDE = 8'd2;
  localparam logic [REC_W-1:0] REC_TO_INCLUDE = 8'd3;
  localparam logic [REC_W-1:0] REC_TO_EXCLUDE = 8'd4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_REPORT,
    OP_TICK,
    OP_DATA
  } op_e;

  typedef struct packed {
    logic [GRP_W-1:0]      group;
    logic                  exclude;
    logic [TIMER_BITS-1:0] timer;
  } entry_t;

  typedef struct packed {
    logic [TIMER_BITS-1:0] gmi;
    logic [TIMER_BITS-1:0] lmqt;
  } timers_t;

  // controller -> datapath
  typedef struct packed {
    logic init;    // latch request, set up scan
    logic issue;   // read the entry at the scan address
    logic finish;  // final update and result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic nop;     // incoming request does no scan
    logic last;    // scan address is the last entry of the scan
  } status_t;

endpackage

@@ sv/igmp_regs.sv @@
// Configuration registers and the derived GMI and LMQT timer values.
// Depends on igmp_pkg.
module igmp_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [igmp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [igmp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output igmp_pkg::timers_t                 timers_o
);

  logic [2:0]  robust_q;
  logic [15:0] qintv_q;
  logic [7:0]  rintv_q;
  logic [7:0]  lmintv_q;
  logic [7:0]  lmcnt_q;

  logic [18:0]                     gmi_prod;
  logic [15:0]                     lmqt_prod;
  logic [igmp_pkg::CALC_W-1:0]     gmi_sum;
  logic [igmp_pkg::CALC_W-1:0]     lmqt_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robust_q <= 3'd2;
      qintv_q  <= 16'd1250;
      rintv_q  <= 8'd100;
      lmintv_q <= 8'd10;
      lmcnt_q  <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        igmp_pkg::CFG_ROBUSTNESS: robust_q <= cfg_wdata_i[2:0];
        igmp_pkg::CFG_QUERY_INTV: qintv_q  <= cfg_wdata_i;
        igmp_pkg::CFG_RESP_INTV:  rintv_q  <= cfg_wdata_i[7:0];
        igmp_pkg::CFG_LM_INTV:    lmintv_q <= cfg_wdata_i[7:0];
        igmp_pkg::CFG_LM_COUNT:   lmcnt_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign gmi_prod  = 19'(robust_q) * 19'(qintv_q);
  assign lmqt_prod = 16'(lmintv_q) * 16'(lmcnt_q);
  assign gmi_sum   = igmp_pkg::CALC_W'(gmi_prod) + igmp_pkg::CALC_W'(rintv_q);
  assign lmqt_ext  = igmp_pkg::CALC_W'(lmqt_prod);

  // saturate to the timer width
  always_comb begin
    timers_o.gmi  = (gmi_sum > igmp_pkg::TIMER_SAT) ?
                    igmp_pkg::TIMER_BITS'(igmp_pkg::TIMER_SAT) :
                    igmp_pkg::TIMER_BITS'(gmi_sum);
    timers_o.lmqt = (lmqt_ext > igmp_pkg::TIMER_SAT) ?
                    igmp_pkg::TIMER_BITS'(igmp_pkg::TIMER_SAT) :
                    igmp_pkg::TIMER_BITS'(lmqt_ext);
  end

endmodule

@@ sv/igmp_ctrl.sv @@
// Sequencer for one request: accept, scan entries, drain, finish; an ignored request goes straight to finish.
// Depends on igmp_pkg.
module igmp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  igmp_pkg::status_t   status_i,
  output igmp_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.init = 1'b1;
          state_d    = status_i.nop ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ sv/igmp_dp.sv @@
// Datapath: entry memory, valid bits, scan counters, per-entry update, results.
// Depends on igmp_pkg.
module igmp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  igmp_pkg::cmd_t                    cmd_i,
  output igmp_pkg::status_t                 status_o,
  input  igmp_pkg::timers_t                 timers_i,
  input  logic [igmp_pkg::REQ_W-1:0]        req_type_i,
  input  logic [igmp_pkg::PORTF_W-1:0]      port_i,
  input  logic [igmp_pkg::REC_W-1:0]        record_type_i,
  input  logic [igmp_pkg::GRP_W-1:0]        group_address_i,
  output logic                              result_valid_o,
  output logic [igmp_pkg::FWD_W-1:0]        forward_mask_o,
  output logic                              query_valid_o,
  output logic [igmp_pkg::PORTF_W-1:0]      query_port_o,
  output logic [igmp_pkg::GRP_W-1:0]        query_group_o,
  output logic                              table_full_o
);

  localparam int AW = igmp_pkg::ADDR_W;
  localparam int PW = igmp_pkg::PORT_W;
  localparam int KW = igmp_pkg::K_W;
  localparam int TW = igmp_pkg::TIMER_BITS;

  igmp_pkg::entry_t mem [igmp_pkg::ENTRY_COUNT];
  igmp_pkg::entry_t rdata_q;
  logic [igmp_pkg::ENTRY_COUNT-1:0] valid_q;

  igmp_pkg::op_e                    op_q, op_in;
  logic [igmp_pkg::REC_W-1:0]       rec_q;
  logic [igmp_pkg::GRP_W-1:0]       grp_q;
  logic [igmp_pkg::PORTF_W-1:0]     rport_q;

  logic [AW-1:0] addr_q;
  logic [PW-1:0] p_q;
  logic [KW-1:0] k_q;

  // read-data stage
  logic          sv_q;
  logic [AW-1:0] sa_q;
  logic [PW-1:0] sp_q;

  logic          found_q, found_excl_q, free_q;
  logic [AW-1:0] found_addr_q, free_addr_q;
  logic [igmp_pkg::FWD_W-1:0] fwd_q;

  logic             we;
  logic [AW-1:0]    waddr;
  igmp_pkg::entry_t wdata;
  logic             s_valid, s_match;
  logic             q_hit, join_new, join_full;

  always_comb begin
    op_in = igmp_pkg::OP_NONE;
    unique case (req_type_i)
      igmp_pkg::REQ_REPORT:
        if (32'(port_i) < igmp_pkg::PORT_COUNT) op_in = igmp_pkg::OP_REPORT;
      igmp_pkg::REQ_TICK: op_in = igmp_pkg::OP_TICK;
      igmp_pkg::REQ_DATA: op_in = igmp_pkg::OP_DATA;
      default: op_in = igmp_pkg::OP_NONE;
    endcase
  end

  assign status_o.nop  = (op_in == igmp_pkg::OP_NONE);
  assign status_o.last = (k_q == KW'(igmp_pkg::GROUPS_PER_PORT - 1)) &&
                         ((op_q == igmp_pkg::OP_REPORT) ||
                          (p_q == PW'(igmp_pkg::PORT_COUNT - 1)));

  assign s_valid = valid_q[sa_q];
  assign s_match = s_valid && (rdata_q.group == grp_q);

  // report outcomes at finish
  assign q_hit     = cmd_i.finish && (op_q == igmp_pkg::OP_REPORT) &&
                     (rec_q == igmp_pkg::REC_TO_INCLUDE) && found_q;
  assign join_new  = cmd_i.finish && (op_q == igmp_pkg::OP_REPORT) &&
                     (rec_q == igmp_pkg::REC_TO_EXCLUDE) && !found_q && free_q;
  assign join_full = cmd_i.finish && (op_q == igmp_pkg::OP_REPORT) &&
                     (rec_q == igmp_pkg::REC_TO_EXCLUDE) && !found_q && !free_q;

  // memory write: tick write-back in the data stage, report update at finish
  always_comb begin
    we    = 1'b0;
    waddr = sa_q;
    wdata = rdata_q;
    if (sv_q && op_q == igmp_pkg::OP_TICK && s_valid) begin
      we = 1'b1;
      if (rdata_q.timer == '0) begin
        wdata.exclude = 1'b0;
      end else begin
        wdata.timer = rdata_q.timer - TW'(1);
      end
    end else if (cmd_i.finish && op_q == igmp_pkg::OP_REPORT) begin
      waddr         = found_addr_q;
      wdata.group   = grp_q;
      wdata.exclude = found_excl_q;
      wdata.timer   = timers_i.gmi;
      case (rec_q)
        igmp_pkg::REC_IS_EXCLUDE: we = found_q;
        igmp_pkg::REC_TO_INCLUDE: begin
          we          = found_q;
          wdata.timer = timers_i.lmqt;
        end
        igmp_pkg::REC_TO_EXCLUDE: begin
          we            = found_q || free_q;
          wdata.exclude = 1'b1;
          if (!found_q) waddr = free_addr_q;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.issue) rdata_q <= mem[addr_q];
  end

  // request payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      rec_q   <= record_type_i;
      grp_q   <= group_address_i;
      rport_q <= port_i;
    end
    if (cmd_i.issue) begin
      sa_q <= addr_q;
      sp_q <= p_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q           <= igmp_pkg::OP_NONE;
      addr_q         <= '0;
      p_q            <= '0;
      k_q            <= '0;
      sv_q           <= 1'b0;
      found_q        <= 1'b0;
      found_excl_q   <= 1'b0;
      found_addr_q   <= '0;
      free_q         <= 1'b0;
      free_addr_q    <= '0;
      fwd_q          <= '0;
      valid_q        <= '0;
      result_valid_o <= 1'b0;
      forward_mask_o <= '0;
      query_valid_o  <= 1'b0;
      query_port_o   <= '0;
      query_group_o  <= '0;
      table_full_o   <= 1'b0;
    end else begin
      sv_q           <= cmd_i.issue;
      result_valid_o <= cmd_i.finish;

      if (cmd_i.init) begin
        op_q    <= op_in;
        found_q <= 1'b0;
        free_q  <= 1'b0;
        fwd_q   <= '0;
        k_q     <= '0;
        if (op_in == igmp_pkg::OP_REPORT) begin
          p_q    <= PW'(port_i);
          addr_q <= AW'(32'(port_i) * igmp_pkg::GROUPS_PER_PORT);
        end else begin
          p_q    <= '0;
          addr_q <= '0;
        end
      end

      if (cmd_i.issue) begin
        addr_q <= AW'(addr_q + AW'(1));
        if (k_q == KW'(igmp_pkg::GROUPS_PER_PORT - 1)) begin
          k_q <= '0;
          p_q <= PW'(p_q + PW'(1));
        end else begin
          k_q <= KW'(k_q + KW'(1));
        end
      end

      if (sv_q) begin
        case (op_q)
          igmp_pkg::OP_REPORT: begin
            if (s_match && !found_q) begin
              found_q      <= 1'b1;
              found_addr_q <= sa_q;
              found_excl_q <= rdata_q.exclude;
            end
            if (!s_valid && !free_q) begin
              free_q      <= 1'b1;
              free_addr_q <= sa_q;
            end
          end
          igmp_pkg::OP_DATA: begin
            if (s_match) begin
              if (rdata_q.timer == '0 && !rdata_q.exclude) begin
                valid_q[sa_q] <= 1'b0;
              end else if (rdata_q.exclude && rdata_q.timer != '0) begin
                for (int j = 0; j < igmp_pkg::FWD_W; j++) begin
                  if ((j < igmp_pkg::PORT_COUNT) && (32'(sp_q) == j)) fwd_q[j] <= 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end

      // result fields are nonzero only in the strobe cycle
      forward_mask_o <= (cmd_i.finish && op_q == igmp_pkg::OP_DATA) ? fwd_q : '0;
      query_valid_o  <= q_hit;
      query_port_o   <= q_hit ? rport_q : '0;
      query_group_o  <= q_hit ? grp_q : '0;
      table_full_o   <= join_full;
      if (join_new) valid_q[free_addr_q] <= 1'b1;
    end
  end

endmodule

@@ sv/igmp_group_membership_table_top.sv @@
// IGMPv3 group membership table top: regs, controller, datapath (igmp_pkg, igmp_regs,
// igmp_ctrl, igmp_dp). A report scans its port's GROUPS_PER_PORT entries, a tick or data
// packet all ENTRY_COUNT entries, then drain and finish; an ignored request goes to finish.
// The next start is taken while the result strobe is up; the scan reads the entry
// memory one entry per cycle, and a new request waits until the current one is done.
// Reset clears all valid bits at once; the result can not be stalled.
module igmp_group_membership_table_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [igmp_pkg::REQ_W-1:0]        req_type_i,
  input  logic [igmp_pkg::PORTF_W-1:0]      port_i,
  input  logic [igmp_pkg::REC_W-1:0]        record_type_i,
  input  logic [igmp_pkg::GRP_W-1:0]        group_address_i,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [igmp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [igmp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // result, one-cycle strobe
  output logic                              result_valid_o,
  output logic [igmp_pkg::FWD_W-1:0]        forward_mask_o,
  output logic                              query_valid_o,
  output logic [igmp_pkg::PORTF_W-1:0]      query_port_o,
  output logic [igmp_pkg::GRP_W-1:0]        query_group_o,
  output logic                              table_full_o
);

  igmp_pkg::timers_t timers;
  igmp_pkg::cmd_t    cmd;
  igmp_pkg::status_t status;

  // GMI / LMQT come straight from the registers, so a write is in effect
  // for the very next request.
  igmp_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .timers_o    (timers)
  );

  // Sequencer: idle -> scan (one read per cycle) -> drain -> finish, or idle -> finish if ignored.
  igmp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Reports scan only their own port's slice; ticks and data packets
  // walk the whole table. Result fields are registered.
  igmp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .timers_i        (timers),
    .req_type_i      (req_type_i),
    .port_i          (port_i),
    .record_type_i   (record_type_i),
    .group_address_i (group_address_i),
    .result_valid_o  (result_valid_o),
    .forward_mask_o  (forward_mask_o),
    .query_valid_o   (query_valid_o),
    .query_port_o    (query_port_o),
    .query_group_o   (query_group_o),
    .table_full_o    (table_full_o)
  );

  // a result always closes a request that was in flight
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result strobe without a request in flight");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // query and table-full flags are only set alongside the strobe
  a_fields_with_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_valid_o || table_full_o) |-> result_valid_o)
    else $error("query or full flag outside a result");

  // a report result never carries a forward mask
  a_exclusive_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_valid_o || table_full_o) |-> (forward_mask_o == '0))
    else $error("report result with a forward mask");

endmodule

@@ tb/igmp_group_membership_table_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for igmp_group_membership_table_top: a directed table, then
// random report/tick/data requests checked against a behavioral table model.
// Depends on igmp_pkg and the RTL of the block.
module igmp_group_membership_table_top_tb;

  localparam int SEGMENTS       = 9;      // three idle modes, three settings each
  localparam int SEGMENT_ITEMS  = 90;     // non-ignored requests per segment
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = igmp_pkg::ENTRY_COUNT + 8;
  localparam int MAX_GAP        = 60;     // longer than a full table scan
  localparam int POOL_SIZE      = 20;     // more groups than one port table holds
  localparam longint TIMEOUT_NS = 5_000_000;

  localparam logic [igmp_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;   // decodes to nothing
  localparam logic [igmp_pkg::GRP_W-1:0]     GRP_A         = 32'hE000_0001;
  localparam logic [igmp_pkg::GRP_W-1:0]     GRP_ONES      = 32'hFFFF_FFFF;
  localparam logic [igmp_pkg::GRP_W-1:0]     GRP_ZERO      = 32'h0000_0000;
  localparam logic [igmp_pkg::REC_W-1:0]     REC_BOGUS     = 8'hFF;
  localparam logic [igmp_pkg::REQ_W-1:0]     REQ_UNKNOWN   = 2'd3;

  typedef struct packed {
    logic [igmp_pkg::FWD_W-1:0]   fwd_mask;
    logic                         q_valid;
    logic [igmp_pkg::PORTF_W-1:0] q_port;
    logic [igmp_pkg::GRP_W-1:0]   q_group;
    logic                         full;
  } membership_result_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    logic [igmp_pkg::REQ_W-1:0]      req;
    logic [igmp_pkg::PORTF_W-1:0]    prt;
    logic [igmp_pkg::REC_W-1:0]      rec;
    logic [igmp_pkg::GRP_W-1:0]      grp;
    logic [igmp_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [igmp_pkg::CFG_DATA_W-1:0] cfg_data;
    bit                              typed;      // expected result written in the row
    membership_result_t              result;
  } directed_row_t;

  // DUT ports
  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic [igmp_pkg::REQ_W-1:0]      req_type_i;
  logic [igmp_pkg::PORTF_W-1:0]    port_i;
  logic [igmp_pkg::REC_W-1:0]      record_type_i;
  logic [igmp_pkg::GRP_W-1:0]      group_address_i;
  logic                            cfg_we_i;
  logic [igmp_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [igmp_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                            result_valid_o;
  logic [igmp_pkg::FWD_W-1:0]      forward_mask_o;
  logic                            query_valid_o;
  logic [igmp_pkg::PORTF_W-1:0]    query_port_o;
  logic [igmp_pkg::GRP_W-1:0]      query_group_o;
  logic                            table_full_o;

  // Table model: configuration and per-entry state
  logic [2:0]                      cur_robustness;
  logic [15:0]                     cur_query_intv;
  logic [7:0]                      cur_resp_intv;
  logic [7:0]                      cur_lm_intv;
  logic [7:0]                      cur_lm_count;
  logic                            tbl_valid   [igmp_pkg::ENTRY_COUNT];
  logic [igmp_pkg::GRP_W-1:0]      tbl_group   [igmp_pkg::ENTRY_COUNT];
  logic                            tbl_exclude [igmp_pkg::ENTRY_COUNT];
  logic [igmp_pkg::TIMER_BITS-1:0] tbl_timer   [igmp_pkg::ENTRY_COUNT];

  membership_result_t pending_results[$];   // oldest first
  directed_row_t      directed_rows[$];

  // Request side hint from the driver: use a hand-written result for this request
  bit                 row_typed;
  membership_result_t row_result;

  int mismatches;
  int results_seen;
  int n_reports, n_ticks, n_data, n_ignored;
  int n_queries, n_full, n_forwards;

  igmp_group_membership_table_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .port_i          (port_i),
    .record_type_i   (record_type_i),
    .group_address_i (group_address_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .forward_mask_o  (forward_mask_o),
    .query_valid_o   (query_valid_o),
    .query_port_o    (query_port_o),
    .query_group_o   (query_group_o),
    .table_full_o    (table_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or stops producing results
  initial begin
    #(TIMEOUT_NS);
    $display("timeout after %0t", $time);
    $display("igmp_group_membership_table_top_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model of the table
  // ---------------------------------------------------------------------------

  // Group membership interval, saturated to the timer width
  function automatic logic [igmp_pkg::TIMER_BITS-1:0] membership_interval();
    longint unsigned v;
    v = longint'(cur_robustness) * longint'(cur_query_intv) + longint'(cur_resp_intv);
    return (v > igmp_pkg::TIMER_SAT) ? igmp_pkg::TIMER_SAT[igmp_pkg::TIMER_BITS-1:0] :
                                       v[igmp_pkg::TIMER_BITS-1:0];
  endfunction

  // Last member query time, saturated the same way
  function automatic logic [igmp_pkg::TIMER_BITS-1:0] last_member_time();
    longint unsigned v;
    v = longint'(cur_lm_intv) * longint'(cur_lm_count);
    return (v > igmp_pkg::TIMER_SAT) ? igmp_pkg::TIMER_SAT[igmp_pkg::TIMER_BITS-1:0] :
                                       v[igmp_pkg::TIMER_BITS-1:0];
  endfunction

  task automatic predict_membership(input logic [igmp_pkg::REQ_W-1:0] req,
                                    input logic [igmp_pkg::PORTF_W-1:0] prt,
                                    input logic [igmp_pkg::REC_W-1:0] rec,
                                    input logic [igmp_pkg::GRP_W-1:0] grp,
                                    output membership_result_t r);
    int base;
    int found;
    int free_slot;
    int e;
    r = '0;
    if (req == igmp_pkg::REQ_REPORT && prt < igmp_pkg::PORT_COUNT) begin
      base      = int'(prt) * igmp_pkg::GROUPS_PER_PORT;
      found     = -1;
      free_slot = -1;
      // first matching entry and first free slot of this port
      for (int k = 0; k < igmp_pkg::GROUPS_PER_PORT; k++) begin
        e = base + k;
        if (tbl_valid[e]) begin
          if (tbl_group[e] == grp && found < 0) found = e;
        end else if (free_slot < 0) begin
          free_slot = e;
        end
      end
      if (rec == igmp_pkg::REC_IS_EXCLUDE) begin
        // refresh: timer only, mode untouched, never creates
        if (found >= 0) tbl_timer[found] = membership_interval();
      end else if (rec == igmp_pkg::REC_TO_INCLUDE) begin
        if (found >= 0) begin
          tbl_timer[found] = last_member_time();
          r.q_valid = 1'b1;
          r.q_port  = prt;
          r.q_group = grp;
        end
      end else if (rec == igmp_pkg::REC_TO_EXCLUDE) begin
        if (found >= 0) begin
          tbl_exclude[found] = 1'b1;
          tbl_timer[found]   = membership_interval();
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot]   = 1'b1;
          tbl_group[free_slot]   = grp;
          tbl_exclude[free_slot] = 1'b1;
          tbl_timer[free_slot]   = membership_interval();
        end else begin
          r.full = 1'b1;
        end
      end
    end else if (req == igmp_pkg::REQ_TICK) begin
      for (int i = 0; i < igmp_pkg::ENTRY_COUNT; i++) begin
        if (tbl_valid[i]) begin
          if (tbl_timer[i] == '0) tbl_exclude[i] = 1'b0;
          else tbl_timer[i] = tbl_timer[i] - 1'b1;
        end
      end
    end else if (req == igmp_pkg::REQ_DATA) begin
      for (int p = 0; p < igmp_pkg::PORT_COUNT; p++) begin
        for (int k = 0; k < igmp_pkg::GROUPS_PER_PORT; k++) begin
          e = p * igmp_pkg::GROUPS_PER_PORT + k;
          if (!tbl_valid[e] || tbl_group[e] != grp) continue;
          // expired include entry is dropped on lookup
          if (tbl_timer[e] == '0 && !tbl_exclude[e]) begin
            tbl_valid[e] = 1'b0;
            continue;
          end
          if (tbl_exclude[e] && tbl_timer[e] != '0 && p < igmp_pkg::FWD_W)
            r.fwd_mask[p] = 1'b1;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and request tracking, all on the rising edge
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: result %0d %s expected %0h got %0h at %0t",
                 results_seen, name, want, got, $time);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    membership_result_t got;
    membership_result_t want;
    membership_result_t pred;
    if (rst_ni) begin
      // Result of an older request first: the next request may be taken at the
      // same edge as the strobe.
      if (result_valid_o) begin
        got.fwd_mask = forward_mask_o;
        got.q_valid  = query_valid_o;
        got.q_port   = query_port_o;
        got.q_group  = query_group_o;
        got.full     = table_full_o;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: result with no request outstanding at %0t", $time);
        end else begin
          want = pending_results.pop_front();
          check_field("forward_mask", 32'(want.fwd_mask), 32'(got.fwd_mask));
          check_field("query_valid", 32'(want.q_valid), 32'(got.q_valid));
          check_field("query_port", 32'(want.q_port), 32'(got.q_port));
          check_field("query_group", 32'(want.q_group), 32'(got.q_group));
          check_field("table_full", 32'(want.full), 32'(got.full));
        end
        results_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          igmp_pkg::CFG_ROBUSTNESS: cur_robustness = cfg_wdata_i[2:0];
          igmp_pkg::CFG_QUERY_INTV: cur_query_intv = cfg_wdata_i[15:0];
          igmp_pkg::CFG_RESP_INTV:  cur_resp_intv  = cfg_wdata_i[7:0];
          igmp_pkg::CFG_LM_INTV:    cur_lm_intv    = cfg_wdata_i[7:0];
          igmp_pkg::CFG_LM_COUNT:   cur_lm_count   = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        predict_membership(req_type_i, port_i, record_type_i, group_address_i, pred);
        pending_results.insert(pending_results.size(), row_typed ? row_result : pred);
        case (req_type_i)
          igmp_pkg::REQ_REPORT: n_reports++;
          igmp_pkg::REQ_TICK:   n_ticks++;
          igmp_pkg::REQ_DATA:   n_data++;
          default:              n_ignored++;
        endcase
        n_queries  += int'(pred.q_valid);
        n_full     += int'(pred.full);
        n_forwards += int'(pred.fwd_mask != '0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks: every action starts on a falling edge
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [igmp_pkg::REQ_W-1:0] req,
                              input logic [igmp_pkg::PORTF_W-1:0] prt,
                              input logic [igmp_pkg::REC_W-1:0] rec,
                              input logic [igmp_pkg::GRP_W-1:0] grp,
                              input bit typed, input membership_result_t res);
    @(negedge clk_i);
    start_i         <= 1'b1;
    req_type_i      <= req;
    port_i          <= prt;
    record_type_i   <= rec;
    group_address_i <= grp;
    row_typed        = typed;
    row_result       = res;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [igmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [igmp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [15:0] rc, input logic [15:0] qi,
                                input logic [15:0] ri, input logic [15:0] li,
                                input logic [15:0] lc);
    write_cfg(igmp_pkg::CFG_ROBUSTNESS, rc);
    write_cfg(igmp_pkg::CFG_QUERY_INTV, qi);
    write_cfg(igmp_pkg::CFG_RESP_INTV, ri);
    write_cfg(igmp_pkg::CFG_LM_INTV, li);
    write_cfg(igmp_pkg::CFG_LM_COUNT, lc);
    cfg_release();
  endtask

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic membership_result_t mk_result(input logic [igmp_pkg::FWD_W-1:0] fwd,
                                                   input logic qv,
                                                   input logic [igmp_pkg::PORTF_W-1:0] qp,
                                                   input logic [igmp_pkg::GRP_W-1:0] qg,
                                                   input logic full);
    membership_result_t r;
    r.fwd_mask = fwd;
    r.q_valid  = qv;
    r.q_port   = qp;
    r.q_group  = qg;
    r.full     = full;
    return r;
  endfunction

  function automatic directed_row_t req_row(input logic [igmp_pkg::REQ_W-1:0] req,
                                            input logic [igmp_pkg::PORTF_W-1:0] prt,
                                            input logic [igmp_pkg::REC_W-1:0] rec,
                                            input logic [igmp_pkg::GRP_W-1:0] grp,
                                            input bit typed, input membership_result_t res);
    directed_row_t row;
    row.kind     = ROW_REQ;
    row.req      = req;
    row.prt      = prt;
    row.rec      = rec;
    row.grp      = grp;
    row.cfg_idx  = '0;
    row.cfg_data = '0;
    row.typed    = typed;
    row.result   = res;
    return row;
  endfunction

  function automatic directed_row_t cfg_row(input logic [igmp_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [igmp_pkg::CFG_DATA_W-1:0] data);
    directed_row_t row;
    row       = req_row(REQ_UNKNOWN, '0, '0, '0, 1'b0, '0);
    row.kind     = ROW_CFG;
    row.cfg_idx  = idx;
    row.cfg_data = data;
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input directed_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Group pool: a handful of ordinary groups plus the all-zero and all-one addresses
  function automatic logic [igmp_pkg::GRP_W-1:0] pool_group(input int idx);
    if (idx == POOL_SIZE - 2) return GRP_ZERO;
    if (idx == POOL_SIZE - 1) return GRP_ONES;
    return 32'hE000_0100 + 32'(idx);
  endfunction

  // Mostly well-formed traffic on the pool; some pure noise to hit every field bit
  task automatic pick_request(output logic [igmp_pkg::REQ_W-1:0] req,
                              output logic [igmp_pkg::PORTF_W-1:0] prt,
                              output logic [igmp_pkg::REC_W-1:0] rec,
                              output logic [igmp_pkg::GRP_W-1:0] grp);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      req = 2'($urandom);
      prt = 2'($urandom);
      rec = 8'($urandom);
      grp = $urandom_range(0, 1) ? $urandom : pool_group($urandom_range(0, POOL_SIZE - 1));
    end else begin
      prt  = 2'($urandom_range(0, igmp_pkg::PORT_COUNT - 1));
      grp  = pool_group($urandom_range(0, POOL_SIZE - 1));
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        req  = igmp_pkg::REQ_REPORT;
        roll = $urandom_range(0, 99);
        if (roll < 45)      rec = igmp_pkg::REC_TO_EXCLUDE;
        else if (roll < 70) rec = igmp_pkg::REC_IS_EXCLUDE;
        else if (roll < 95) rec = igmp_pkg::REC_TO_INCLUDE;
        else                rec = 8'($urandom);
      end else if (roll < 80) begin
        // port and record are don't-cares on a tick
        req = igmp_pkg::REQ_TICK;
        prt = 2'($urandom);
        rec = 8'($urandom);
      end else begin
        req = igmp_pkg::REQ_DATA;
        prt = 2'($urandom);
        rec = 8'($urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [igmp_pkg::REQ_W-1:0]   req;
    logic [igmp_pkg::PORTF_W-1:0] prt;
    logic [igmp_pkg::REC_W-1:0]   rec;
    logic [igmp_pkg::GRP_W-1:0]   grp;
    int idle_pct;
    int useful;
    int drain;

    rst_ni          = 1'b0;
    start_i         = 1'b0;
    req_type_i      = '0;
    port_i          = '0;
    record_type_i   = '0;
    group_address_i = '0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    row_typed       = 1'b0;
    row_result      = '0;
    mismatches      = 0;
    results_seen    = 0;
    n_reports = 0; n_ticks = 0; n_data = 0; n_ignored = 0;
    n_queries = 0; n_full = 0; n_forwards = 0;

    // model after reset: register defaults, empty tables
    cur_robustness = 3'd2;
    cur_query_intv = 16'd1250;
    cur_resp_intv  = 8'd100;
    cur_lm_intv    = 8'd10;
    cur_lm_count   = 8'd2;
    for (int i = 0; i < igmp_pkg::ENTRY_COUNT; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_group[i]   = '0;
      tbl_exclude[i] = 1'b0;
      tbl_timer[i]   = '0;
    end

    // Directed table, reset register values (GMI 2600, LMQT 20).
    // Typed rows carry their expected result, the rest go through the model.
    add_row(req_row(igmp_pkg::REQ_DATA, 2'd0, 8'd0, GRP_A, 1'b1, '0));  // empty table
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd0, igmp_pkg::REC_TO_EXCLUDE, GRP_A, 1'b1, '0));
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd2, igmp_pkg::REC_TO_EXCLUDE, GRP_A, 1'b1, '0));
    add_row(req_row(igmp_pkg::REQ_DATA, 2'd1, 8'd0, GRP_A, 1'b1,
                    mk_result(3'b101, 1'b0, 2'd0, '0, 1'b0)));
    // leave of a present group asks for a query
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd0, igmp_pkg::REC_TO_INCLUDE, GRP_A, 1'b1,
                    mk_result(3'b000, 1'b1, 2'd0, GRP_A, 1'b0)));
    // leave and refresh of a missing group: no query, nothing created
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd1, igmp_pkg::REC_TO_INCLUDE, GRP_A, 1'b1, '0));
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd1, igmp_pkg::REC_IS_EXCLUDE, GRP_A, 1'b1, '0));
    add_row(req_row(igmp_pkg::REQ_DATA, 2'd0, 8'd0, GRP_A, 1'b1,
                    mk_result(3'b101, 1'b0, 2'd0, '0, 1'b0)));
    // unknown record, report on a nonexistent port, unknown request code
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd1, REC_BOGUS, GRP_A, 1'b1, '0));
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd3, igmp_pkg::REC_TO_EXCLUDE, GRP_A, 1'b1, '0));
    add_row(req_row(REQ_UNKNOWN, 2'd3, REC_BOGUS, GRP_ONES, 1'b1, '0));
    // extreme group addresses
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd1, igmp_pkg::REC_TO_EXCLUDE, GRP_ONES,
                    1'b1, '0));
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd1, igmp_pkg::REC_TO_EXCLUDE, GRP_ZERO,
                    1'b1, '0));
    add_row(req_row(igmp_pkg::REQ_DATA, 2'd3, REC_BOGUS, GRP_ONES, 1'b1,
                    mk_result(3'b010, 1'b0, 2'd0, '0, 1'b0)));
    add_row(req_row(igmp_pkg::REQ_DATA, 2'd0, 8'd0, GRP_ZERO, 1'b1,
                    mk_result(3'b010, 1'b0, 2'd0, '0, 1'b0)));
    add_row(req_row(igmp_pkg::REQ_TICK, 2'd3, REC_BOGUS, GRP_ONES, 1'b1, '0));
    // zero last member time: the leave lands at timer zero
    add_row(cfg_row(igmp_pkg::CFG_LM_INTV, 16'd0));
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd2, igmp_pkg::REC_TO_INCLUDE, GRP_A, 1'b1,
                    mk_result(3'b000, 1'b1, 2'd2, GRP_A, 1'b0)));
    add_row(req_row(igmp_pkg::REQ_DATA, 2'd0, 8'd0, GRP_A, 1'b0, '0));
    add_row(req_row(igmp_pkg::REQ_TICK, 2'd0, 8'd0, GRP_ZERO, 1'b0, '0));
    add_row(req_row(igmp_pkg::REQ_DATA, 2'd0, 8'd0, GRP_A, 1'b0, '0));  // drops port 2
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd2, igmp_pkg::REC_IS_EXCLUDE, GRP_A, 1'b0, '0));
    // refresh keeps exclude mode on port 0
    add_row(req_row(igmp_pkg::REQ_REPORT, 2'd0, igmp_pkg::REC_IS_EXCLUDE, GRP_A, 1'b0, '0));
    add_row(cfg_row(igmp_pkg::CFG_LM_INTV, 16'd10));
    add_row(req_row(igmp_pkg::REQ_TICK, 2'd0, 8'd0, GRP_ZERO, 1'b0, '0));
    add_row(req_row(igmp_pkg::REQ_DATA, 2'd0, 8'd0, GRP_A, 1'b0, '0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_cfg(directed_rows[i].cfg_idx, directed_rows[i].cfg_data);
        cfg_release();
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].prt, directed_rows[i].rec,
                     directed_rows[i].grp, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    // Random segments. Sender idling: 36 % for the first three, 52 % for the
    // next three, none for the last three. Each segment starts idle with a
    // new register setting; small timers let entries expire and get dropped.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      case (seg)
        0, 5: write_all_regs(16'd1, 16'd3, 16'd2, 16'd1, 16'd2);
        1, 6: begin
          // full-width data, upper bits must be dropped by the registers
          write_cfg(CFG_SPARE_IDX, 16'($urandom));
          write_all_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
        end
        2:    write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3:    write_all_regs(16'd3, 16'd4, 16'd8, 16'd3, 16'd2);
        4:    write_all_regs(16'd7, 16'hFFFF, 16'd255, 16'd255, 16'd255);
        7:    write_all_regs(16'd2, 16'd1, 16'd1, 16'd1, 16'd1);
        default: write_all_regs(16'd2, 16'd1250, 16'd100, 16'd10, 16'd2);
      endcase
      idle_pct = (seg < 3) ? 36 : (seg < 6) ? 52 : 0;
      useful   = 0;
      while (useful < SEGMENT_ITEMS) begin
        pick_request(req, prt, rec, grp);
        if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, MAX_GAP));
        if ($urandom_range(0, 99) < 2) wait_drained();
        send_request(req, prt, rec, grp, 1'b0, '0);
        // requests the block just ignores do not count toward the segment
        if (!(req == REQ_UNKNOWN ||
              (req == igmp_pkg::REQ_REPORT && (prt >= igmp_pkg::PORT_COUNT ||
               !(rec == igmp_pkg::REC_IS_EXCLUDE || rec == igmp_pkg::REC_TO_INCLUDE ||
                 rec == igmp_pkg::REC_TO_EXCLUDE)))))
          useful++;
      end
    end

    // Drain, then watch a full scan time for stray results
    @(negedge clk_i);
    start_i <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("ERROR: %0d results never arrived", pending_results.size());
    end

    $display("covered %0d reports, %0d ticks, %0d data packets, %0d ignored requests",
             n_reports, n_ticks, n_data, n_ignored);
    $display("  with %0d queries, %0d full-table drops, %0d forwarded packets, %0d mismatches",
             n_queries, n_full, n_forwards, mismatches);
    if (mismatches == 0) begin
      $display("igmp_group_membership_table_top_tb passed");
    end else begin
      $display("igmp_group_membership_table_top_tb failed");
    end
    $finish;
  end

endmodule
